@@ sv/qpsk_costas_carrier_sync_core_assert.svh @@
// ----------------------------------------------------------------------------
// QPSK Costas loop core - assertion macros
// Concurrent assertion wrappers, compiled out when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef QPSK_COSTAS_CARRIER_SYNC_CORE_ASSERT_SVH
`define QPSK_COSTAS_CARRIER_SYNC_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define QCS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("qcs assertion failed");
// condition must never be true outside reset
`define QCS_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("qcs forbidden condition seen");
`else
`define QCS_ASSERT(lbl, clk, rstn, prop)
`define QCS_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

@@ sv/qcs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// QPSK Costas loop - package
// Widths, sine table, controller states and command bundle.
// ----------------------------------------------------------------------------
package qcs_pkg;

  localparam int SAMPLE_W = 16;
  localparam int PHASE_W  = 32;
  localparam int LUT_AW   = 10;
  localparam int GAIN_W   = 31;
  localparam int REG_IDX_W = 1;

  localparam int COEF_W   = 17;                 // table value in [-32768, 32768]
  localparam int QIDX_W   = LUT_AW - 1;         // indexes 0 .. QTR
  localparam int QTR      = 1 << (LUT_AW - 2);
  localparam int PROD_W   = SAMPLE_W + COEF_W;
  localparam int SUM_W    = PROD_W + 1;
  localparam int RSH_W    = SUM_W - 15;
  localparam int ERR_W    = SAMPLE_W + 2;
  localparam int GPROD_W  = ERR_W + GAIN_W + 1;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_ALPHA = 1'b0,
    REG_BETA  = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LUT,
    ST_MUL,
    ST_ROT,
    ST_GAIN,
    ST_UPD
  } state_e;

  typedef struct packed {
    logic load_in;
    logic clear;
    logic lut_en;
    logic mul_en;
    logic rot_en;
    logic gain_en;
    logic commit;
  } cmd_t;

  typedef logic [COEF_W-1:0] qtr_tbl_t [0:QTR];

  // quarter-wave sine, Q15, from an integer Taylor series in Q30
  function automatic qtr_tbl_t build_qtr();
    qtr_tbl_t    tbl;
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    for (int r = 0; r <= QTR; r++) begin
      x    = (64'(r) * HALF_PI_Q30) >> (LUT_AW - 2);
      term = x;
      sum  = x;
      for (int n = 1; n <= 8; n++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / 64'((2 * n) * (2 * n + 1));
        if ((n % 2) == 1) begin
          sum = (sum >= term) ? sum - term : 64'd0;
        end else begin
          sum = sum + term;
        end
      end
      v = (sum + 64'd16384) >> 15;
      if (v > 64'd32768) begin
        v = 64'd32768;
      end
      tbl[r] = COEF_W'(v);
    end
    return tbl;
  endfunction

  localparam qtr_tbl_t QTR_TBL = build_qtr();

  function automatic logic signed [COEF_W-1:0] sin_at(input logic [LUT_AW-1:0] k);
    logic [QIDX_W-1:0] r;
    logic [QIDX_W-1:0] idx;
    logic [COEF_W-1:0] mag;
    r   = QIDX_W'(k[LUT_AW-3:0]);
    idx = k[LUT_AW-2] ? QIDX_W'(QTR) - r : r;
    mag = QTR_TBL[idx];
    return k[LUT_AW-1] ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat_sample(
    input logic signed [RSH_W-1:0] v
  );
    logic signed [RSH_W-1:0] hi;
    logic signed [RSH_W-1:0] lo;
    hi = RSH_W'((64'd1 << (SAMPLE_W - 1)) - 64'd1);
    lo = -hi - RSH_W'(1);
    if (v > hi) begin
      return SAMPLE_W'(hi);
    end else if (v < lo) begin
      return SAMPLE_W'(lo);
    end
    return SAMPLE_W'(v);
  endfunction

endpackage

@@ sv/qcs_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// QPSK Costas loop - controller
// Sequences one sample beat through table, multiply, rotate, gain and update.
// ----------------------------------------------------------------------------
module qcs_ctrl import qcs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic action_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      ST_LUT: begin
        cmd_o.lut_en = 1'b1;
        state_d      = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = ST_ROT;
      end
      ST_ROT: begin
        cmd_o.rot_en = 1'b1;
        state_d      = ST_GAIN;
      end
      ST_GAIN: begin
        cmd_o.gain_en = 1'b1;
        state_d       = ST_UPD;
      end
      ST_UPD: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          in_ready_o   = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    // a new beat may enter on the commit cycle
    if (in_valid_i && in_ready_o) begin
      if (action_i) begin
        cmd_o.clear = 1'b1;
      end else begin
        cmd_o.load_in = 1'b1;
        state_d       = ST_LUT;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ sv/qcs_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// QPSK Costas loop - datapath
// Gain registers, derotator, phase detector and loop filter state.
// ----------------------------------------------------------------------------
module qcs_datapath import qcs_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cmd_t                       cmd_i,
  input  logic                       cfg_we_i,
  input  logic [REG_IDX_W-1:0]       cfg_addr_i,
  input  logic [GAIN_W-1:0]          cfg_data_i,
  input  logic signed [SAMPLE_W-1:0] sample_i_i,
  input  logic signed [SAMPLE_W-1:0] sample_q_i,
  output logic signed [SAMPLE_W-1:0] corrected_i_o,
  output logic signed [SAMPLE_W-1:0] corrected_q_o,
  output logic signed [PHASE_W-1:0]  freq_offset_o,
  output logic signed [PHASE_W-1:0]  phase_offset_o
);

  localparam logic signed [SUM_W-1:0] RND = SUM_W'(16384);

  logic [GAIN_W-1:0]          alpha_q, beta_q;
  logic [PHASE_W-1:0]         phase_q, phase_d;
  logic [PHASE_W-1:0]         freq_q, freq_d;
  logic signed [SAMPLE_W-1:0] si_q, sq_q;
  logic signed [COEF_W-1:0]   sin_q, cos_q;
  logic signed [PROD_W-1:0]   p_ic_q, p_qs_q, p_qc_q, p_is_q;
  logic signed [SAMPLE_W-1:0] ri_q, rq_q;
  logic signed [GPROD_W-1:0]  pa_q, pb_q;
  logic signed [SAMPLE_W-1:0] cor_i_q, cor_q_q;
  logic [PHASE_W-1:0]         fo_q, po_q;

  logic [LUT_AW-1:0]          lut_idx;
  logic signed [SUM_W-1:0]    sum_i, sum_q;
  logic signed [ERR_W-1:0]    ri_x, rq_x, err;
  logic [PHASE_W-1:0]         delta_a, delta_b, freq_new, phase_new;

  assign lut_idx = phase_q[PHASE_W-1 -: LUT_AW];

  assign sum_i = SUM_W'(p_ic_q) + SUM_W'(p_qs_q) + RND;
  assign sum_q = SUM_W'(p_qc_q) - SUM_W'(p_is_q) + RND;

  assign ri_x = ERR_W'(ri_q);
  assign rq_x = ERR_W'(rq_q);
  assign err  = (rq_q[SAMPLE_W-1] ? -ri_x : ri_x) - (ri_q[SAMPLE_W-1] ? -rq_x : rq_x);

  assign delta_a   = PHASE_W'($signed(pa_q[GPROD_W-1:16]));
  assign delta_b   = PHASE_W'($signed(pb_q[GPROD_W-1:16]));
  assign freq_new  = freq_q - delta_b;
  assign phase_new = phase_q - delta_a + freq_new;

  always_comb begin
    freq_d  = freq_q;
    phase_d = phase_q;
    if (cmd_i.commit) begin
      freq_d  = freq_new;
      phase_d = phase_new;
    end
    if (cmd_i.clear) begin
      freq_d  = '0;
      phase_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= '0;
      beta_q  <= '0;
      phase_q <= '0;
      freq_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_addr_i))
          REG_ALPHA: alpha_q <= cfg_data_i;
          REG_BETA:  beta_q  <= cfg_data_i;
          default: begin
          end
        endcase
      end
      phase_q <= phase_d;
      freq_q  <= freq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      si_q <= sample_i_i;
      sq_q <= sample_q_i;
    end
    if (cmd_i.lut_en) begin
      sin_q <= sin_at(lut_idx);
      cos_q <= sin_at(lut_idx + LUT_AW'(QTR));
    end
    if (cmd_i.mul_en) begin
      p_ic_q <= si_q * cos_q;
      p_qs_q <= sq_q * sin_q;
      p_qc_q <= sq_q * cos_q;
      p_is_q <= si_q * sin_q;
    end
    if (cmd_i.rot_en) begin
      ri_q <= sat_sample(RSH_W'(sum_i >>> 15));
      rq_q <= sat_sample(RSH_W'(sum_q >>> 15));
    end
    if (cmd_i.gain_en) begin
      pa_q <= err * $signed({1'b0, alpha_q});
      pb_q <= err * $signed({1'b0, beta_q});
    end
    if (cmd_i.commit) begin
      cor_i_q <= ri_q;
      cor_q_q <= rq_q;
      fo_q    <= freq_new;
      po_q    <= phase_new;
    end
  end

  assign corrected_i_o  = cor_i_q;
  assign corrected_q_o  = cor_q_q;
  assign freq_offset_o  = $signed(fo_q);
  assign phase_offset_o = $signed(po_q);

endmodule

@@ sv/qpsk_costas_carrier_sync_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// QPSK Costas loop core
// Second-order Costas loop: derotate, detect phase error, update estimates.
// ----------------------------------------------------------------------------
// Accept registers the sample; it then passes table, multiply, rotate, gain
//   and update states; update sets result valid once the output side is free.
// The next sample enters on the cycle its predecessor commits, since its
//   table read needs the updated phase. A clear beat gives no result.
// Reset (async, active low): estimates, gains and the output valid flag to zero.
// ----------------------------------------------------------------------------
`include "qpsk_costas_carrier_sync_core_assert.svh"

module qpsk_costas_carrier_sync_core import qcs_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [REG_IDX_W-1:0]       cfg_addr_i,
  input  logic [GAIN_W-1:0]          cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       action_i,
  input  logic signed [SAMPLE_W-1:0] sample_i_i,
  input  logic signed [SAMPLE_W-1:0] sample_q_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [SAMPLE_W-1:0] corrected_i_o,
  output logic signed [SAMPLE_W-1:0] corrected_q_o,
  output logic signed [PHASE_W-1:0]  freq_offset_o,
  output logic signed [PHASE_W-1:0]  phase_offset_o
);

  cmd_t cmd;

  qcs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  qcs_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_data_i     (cfg_data_i),
    .sample_i_i     (sample_i_i),
    .sample_q_i     (sample_q_i),
    .corrected_i_o  (corrected_i_o),
    .corrected_q_o  (corrected_q_o),
    .freq_offset_o  (freq_offset_o),
    .phase_offset_o (phase_offset_o)
  );

  `QCS_ASSERT_NEVER(a_commit_blocked, clk_i, rst_ni, cmd.commit && out_valid_o && !out_ready_i)
  `QCS_ASSERT_NEVER(a_clear_and_load, clk_i, rst_ni, cmd.clear && cmd.load_in)
  `QCS_ASSERT(a_commit_shows, clk_i, rst_ni, cmd.commit |=> out_valid_o)
  `QCS_ASSERT(a_load_to_lut, clk_i, rst_ni, cmd.load_in |=> cmd.lut_en && !in_ready_o)

endmodule

@@ dv/tb_qpsk_costas_carrier_sync_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// QPSK Costas loop core - testbench
// Feeds sample and clear beats through the valid/ready input, predicts the
// derotated pair and the updated loop estimates, and checks every output beat
// in order. Gains are set between phases while the loop is idle, and the
// output side is stalled at random and once for a long stretch.
// ----------------------------------------------------------------------------
module tb_qpsk_costas_carrier_sync_core import qcs_pkg::*;;

  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_CLEAR  = 1'b1;

  localparam logic signed [SAMPLE_W-1:0] S_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] S_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic [GAIN_W-1:0] GAIN_MAX = {GAIN_W{1'b1}};

  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASE_BEATS   = 250;
  localparam int RUN_LIMIT_NS  = 1000000;

  typedef longint unsigned u64_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] ci;
    logic signed [SAMPLE_W-1:0] cq;
    logic signed [PHASE_W-1:0]  freq;
    logic signed [PHASE_W-1:0]  phase;
  } loop_out_t;

  class costas_scoreboard;
    int                 quarter_sin [0:QTR];
    logic [PHASE_W-1:0] phase_est;
    logic [PHASE_W-1:0] freq_est;
    logic [GAIN_W-1:0]  alpha;
    logic [GAIN_W-1:0]  beta;
    loop_out_t          expected_q [$];
    int                 fails;

    // quarter-wave sine in Q15 from a Taylor series worked in Q30
    function new();
      u64_t x;
      u64_t term;
      u64_t acc;
      u64_t v;
      phase_est = '0;
      freq_est  = '0;
      alpha     = '0;
      beta      = '0;
      fails     = 0;
      for (int r = 0; r <= QTR; r++) begin
        x    = (u64_t'(r) * 64'd1686629713) >> (LUT_AW - 2);
        term = x;
        acc  = x;
        for (int n = 1; n <= 8; n++) begin
          term = (term * x) >> 30;
          term = (term * x) >> 30;
          term = term / u64_t'((2 * n) * (2 * n + 1));
          if ((n % 2) == 1) begin
            acc = (acc >= term) ? acc - term : 64'd0;
          end else begin
            acc = acc + term;
          end
        end
        v = (acc + 64'd16384) >> 15;
        quarter_sin[r] = (v > 64'd32768) ? 32768 : int'(v);
      end
    endfunction

    function void set_gains(logic [GAIN_W-1:0] a, logic [GAIN_W-1:0] b);
      alpha = a;
      beta  = b;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function longint sine(logic [LUT_AW-1:0] k);
      int r;
      int mag;
      r   = int'(k[LUT_AW-3:0]);
      mag = k[LUT_AW-2] ? quarter_sin[QTR - r] : quarter_sin[r];
      return k[LUT_AW-1] ? -longint'(mag) : longint'(mag);
    endfunction

    function longint clip(longint v);
      if (v > longint'(S_MAX)) return longint'(S_MAX);
      if (v < longint'(S_MIN)) return longint'(S_MIN);
      return v;
    endfunction

    function void note_input(logic act, logic signed [SAMPLE_W-1:0] si,
                             logic signed [SAMPLE_W-1:0] sq);
      logic [LUT_AW-1:0] sin_idx;
      logic [LUT_AW-1:0] cos_idx;
      longint            s;
      longint            c;
      longint            ri;
      longint            rq;
      longint            err;
      loop_out_t         o;
      if (act == ACT_CLEAR) begin
        phase_est = '0;
        freq_est  = '0;
        return;
      end
      sin_idx = phase_est[PHASE_W-1 -: LUT_AW];
      cos_idx = sin_idx + LUT_AW'(QTR);
      s  = sine(sin_idx);
      c  = sine(cos_idx);
      ri = clip((longint'(si) * c + longint'(sq) * s + 64'sd16384) >>> 15);
      rq = clip((longint'(sq) * c - longint'(si) * s + 64'sd16384) >>> 15);
      err = ((rq >= 0) ? ri : -ri) - ((ri >= 0) ? rq : -rq);
      freq_est  = freq_est - PHASE_W'((err * longint'(beta)) >>> 16);
      phase_est = phase_est - PHASE_W'((err * longint'(alpha)) >>> 16) + freq_est;
      o.ci    = SAMPLE_W'(ri);
      o.cq    = SAMPLE_W'(rq);
      o.freq  = freq_est;
      o.phase = phase_est;
      expected_q.insert(expected_q.size(), o);
    endfunction

    function void check_result(logic signed [SAMPLE_W-1:0] ci,
                               logic signed [SAMPLE_W-1:0] cq,
                               logic signed [PHASE_W-1:0] freq,
                               logic signed [PHASE_W-1:0] phase);
      loop_out_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected output beat: i %0d q %0d freq %0d phase %0d",
               ci, cq, freq, phase);
        fails++;
        return;
      end
      e = expected_q.pop_front();
      if (ci !== e.ci) begin
        $error("corrected_i: expected %0d, got %0d", e.ci, ci);
        fails++;
      end
      if (cq !== e.cq) begin
        $error("corrected_q: expected %0d, got %0d", e.cq, cq);
        fails++;
      end
      if (freq !== e.freq) begin
        $error("freq_offset: expected %0d, got %0d", e.freq, freq);
        fails++;
      end
      if (phase !== e.phase) begin
        $error("phase_offset: expected %0d, got %0d", e.phase, phase);
        fails++;
      end
    endfunction
  endclass

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       cfg_we_i = 1'b0;
  logic [REG_IDX_W-1:0]       cfg_addr_i = REG_ALPHA;
  logic [GAIN_W-1:0]          cfg_data_i = '0;
  logic                       in_valid_i = 1'b0;
  logic                       in_ready_o;
  logic                       action_i = ACT_SAMPLE;
  logic signed [SAMPLE_W-1:0] sample_i_i = '0;
  logic signed [SAMPLE_W-1:0] sample_q_i = '0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic signed [SAMPLE_W-1:0] corrected_i_o;
  logic signed [SAMPLE_W-1:0] corrected_q_o;
  logic signed [PHASE_W-1:0]  freq_offset_o;
  logic signed [PHASE_W-1:0]  phase_offset_o;

  bit               tx_gaps = 1'b1;
  bit               rx_gaps = 1'b1;
  int               hold_req = 0;
  costas_scoreboard sb;

  qpsk_costas_carrier_sync_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .action_i       (action_i),
    .sample_i_i     (sample_i_i),
    .sample_q_i     (sample_q_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .corrected_i_o  (corrected_i_o),
    .corrected_q_o  (corrected_q_o),
    .freq_offset_o  (freq_offset_o),
    .phase_offset_o (phase_offset_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // output beats are checked before the input beat of the same edge is noted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        sb.check_result(corrected_i_o, corrected_q_o, freq_offset_o, phase_offset_o);
      end
      if (in_valid_i && in_ready_o) begin
        sb.note_input(action_i, sample_i_i, sample_q_i);
      end
    end
  end

  initial begin : receiver
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= !(rx_gaps && ($urandom_range(99) < 15));
      end
    end
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("FAIL qpsk_costas_carrier_sync_core");
    $finish;
  end

  task automatic send_beat(input logic act, input logic signed [SAMPLE_W-1:0] si,
                           input logic signed [SAMPLE_W-1:0] sq);
    while (tx_gaps && ($urandom_range(99) < 15)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    sample_i_i <= si;
    sample_q_i <= sq;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // the extra edge lets the monitor note the last beat before the count is read
  task automatic drain_loop();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_gains(input logic [GAIN_W-1:0] a, input logic [GAIN_W-1:0] b);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= REG_ALPHA;
    cfg_data_i <= a;
    @(posedge clk_i);
    cfg_addr_i <= REG_BETA;
    cfg_data_i <= b;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_gains(a, b);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] corner_value();
    case ($urandom_range(5))
      0:       return S_MIN;
      1:       return SAMPLE_W'(S_MIN + 1);
      2:       return SAMPLE_W'(-1);
      3:       return SAMPLE_W'(0);
      4:       return SAMPLE_W'(1);
      default: return S_MAX;
    endcase
  endfunction

  // mostly noisy QPSK symbols, else raw full-scale noise or corner values
  task automatic draw_sample(output logic signed [SAMPLE_W-1:0] si,
                             output logic signed [SAMPLE_W-1:0] sq);
    int style;
    int amp;
    style = $urandom_range(99);
    amp   = $urandom_range(23000, 6000);
    if (style < 55) begin
      si = SAMPLE_W'(($urandom_range(1) ? amp : -amp) + int'($urandom_range(4000)) - 2000);
      sq = SAMPLE_W'(($urandom_range(1) ? amp : -amp) + int'($urandom_range(4000)) - 2000);
    end else if (style < 85) begin
      si = SAMPLE_W'($urandom);
      sq = SAMPLE_W'($urandom);
    end else begin
      si = corner_value();
      sq = corner_value();
    end
  endtask

  initial begin : stimulus
    logic signed [SAMPLE_W-1:0] si;
    logic signed [SAMPLE_W-1:0] sq;
    logic [GAIN_W-1:0]          alpha_set [6];
    logic [GAIN_W-1:0]          beta_set [6];
    sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero gains: rotation by zero phase, clear on an idle loop
    send_beat(ACT_CLEAR, SAMPLE_W'(0), SAMPLE_W'(0));
    send_beat(ACT_SAMPLE, S_MAX, S_MAX);
    send_beat(ACT_SAMPLE, S_MIN, S_MIN);
    send_beat(ACT_SAMPLE, S_MIN, S_MAX);
    send_beat(ACT_SAMPLE, S_MAX, S_MIN);
    send_beat(ACT_SAMPLE, SAMPLE_W'(0), SAMPLE_W'(0));
    send_beat(ACT_SAMPLE, SAMPLE_W'(1), SAMPLE_W'(-1));
    send_beat(ACT_SAMPLE, SAMPLE_W'(-1), SAMPLE_W'(1));
    send_beat(ACT_SAMPLE, SAMPLE_W'(0), S_MIN);
    drain_loop();

    // full gains: estimates wrap and the phase jumps across the table
    write_gains(GAIN_MAX, GAIN_MAX);
    send_beat(ACT_SAMPLE, S_MAX, SAMPLE_W'(0));
    send_beat(ACT_SAMPLE, SAMPLE_W'(0), S_MAX);
    send_beat(ACT_SAMPLE, S_MIN, SAMPLE_W'(0));
    send_beat(ACT_SAMPLE, SAMPLE_W'(0), S_MIN);
    send_beat(ACT_SAMPLE, SAMPLE_W'(23170), SAMPLE_W'(-23170));
    send_beat(ACT_SAMPLE, S_MAX, S_MAX);
    send_beat(ACT_SAMPLE, S_MIN, S_MIN);
    send_beat(ACT_CLEAR, S_MAX, S_MIN);
    send_beat(ACT_SAMPLE, S_MAX, S_MIN);
    send_beat(ACT_SAMPLE, SAMPLE_W'(-1), SAMPLE_W'(-1));
    send_beat(ACT_SAMPLE, SAMPLE_W'(-21846), SAMPLE_W'(5461));

    alpha_set[0] = GAIN_W'($urandom_range(1 << 20, 1 << 12));
    beta_set[0]  = GAIN_W'($urandom_range(1 << 12, 1 << 6));
    alpha_set[1] = '0;
    beta_set[1]  = GAIN_MAX;
    alpha_set[2] = GAIN_MAX;
    beta_set[2]  = '0;
    alpha_set[3] = GAIN_W'($urandom);
    beta_set[3]  = GAIN_W'($urandom);
    alpha_set[4] = GAIN_W'(1);
    beta_set[4]  = GAIN_W'(1);
    alpha_set[5] = GAIN_W'($urandom_range(1 << 22, 1 << 10));
    beta_set[5]  = GAIN_W'($urandom_range(1 << 16, 1 << 4));

    for (int p = 0; p < 6; p++) begin
      drain_loop();
      tx_gaps = (p != 0);
      rx_gaps = (p != 0);
      write_gains(alpha_set[p], beta_set[p]);
      for (int k = 0; k < PHASE_BEATS; k++) begin
        if (p == 2 && k == 40) begin
          hold_req++;
        end
        draw_sample(si, sq);
        send_beat(($urandom_range(99) < 3) ? ACT_CLEAR : ACT_SAMPLE, si, sq);
      end
    end
    drain_loop();

    if (sb.fails == 0) begin
      $display("PASS qpsk_costas_carrier_sync_core");
    end else begin
      $display("FAIL qpsk_costas_carrier_sync_core");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+sv
sv/qcs_pkg.sv
sv/qcs_ctrl.sv
sv/qcs_datapath.sv
sv/qpsk_costas_carrier_sync_core.sv
dv/tb_qpsk_costas_carrier_sync_core.sv
